// ===== rtl/core/wtsc_pkg.sv =====
package wtsc_pkg;

  localparam int WAVE_BYTES = 16;
  localparam int WAVE_IDX_W = $clog2(WAVE_BYTES);

  localparam logic [15:0] ADDR_DAC      = 16'hff1a;
  localparam logic [15:0] ADDR_LENGTH   = 16'hff1b;
  localparam logic [15:0] ADDR_VOLUME   = 16'hff1c;
  localparam logic [15:0] ADDR_FREQ_LO  = 16'hff1d;
  localparam logic [15:0] ADDR_FREQ_HI  = 16'hff1e;
  localparam logic [15:0] ADDR_WAVE_LO  = 16'hff30;
  localparam logic [15:0] ADDR_WAVE_HI  = 16'hff3f;

  localparam logic [11:0] DIV_PERIOD    = 12'd2048;
  localparam logic [8:0]  LENGTH_FULL   = 9'd256;
  localparam logic [7:0]  READ_IDLE     = 8'hff;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LENGTH = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_RESET  = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        odd;
    logic        init_len;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       chan_on;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [WAVE_IDX_W-1:0] waddr;
    logic [7:0]            wdata;
    logic                  corrupt;
    logic [WAVE_IDX_W-1:0] cur;
  } wave_ctl_t;

endpackage

// ===== rtl/core/wtsc_wave_ram.sv =====
module wtsc_wave_ram (
  input  logic                          clk,
  input  logic                          rst,
  input  wtsc_pkg::wave_ctl_t           ctl,
  input  logic [wtsc_pkg::WAVE_IDX_W-1:0] rd_idx,
  output logic [7:0]                    rd_data
);
  import wtsc_pkg::*;

  logic [7:0] bytes [WAVE_BYTES];

  assign rd_data = bytes[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WAVE_BYTES; i++) bytes[i] <= 8'h00;
    end else if (ctl.we) begin
      bytes[ctl.waddr] <= ctl.wdata;
    end else if (ctl.corrupt) begin
      // copy the current byte, or its aligned group of four, to the front
      if (ctl.cur < WAVE_IDX_W'(4)) begin
        bytes[0] <= bytes[ctl.cur];
      end else begin
        for (int i = 0; i < 4; i++)
          bytes[i] <= bytes[{ctl.cur[WAVE_IDX_W-1:2], 2'(i)}];
      end
    end
  end

endmodule

// ===== rtl/core/wtsc_ctrl.sv =====
module wtsc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  wtsc_pkg::item_t                 item,
  input  logic                            color_mode,
  input  logic [7:0]                      wave_rd_data,
  output logic [wtsc_pkg::WAVE_IDX_W-1:0] wave_rd_idx,
  output wtsc_pkg::wave_ctl_t             wave_ctl,
  output wtsc_pkg::result_t               result
);
  import wtsc_pkg::*;

  logic        chan_enable, chan_enable_next;
  logic        dac_on, dac_on_next;
  logic [1:0]  vol_code, vol_code_next;
  logic [10:0] freq_value, freq_value_next;
  logic        length_enable, length_enable_next;
  logic [3:0]  out_sample, out_sample_next;
  logic [8:0]  length_count, length_count_next;
  logic [11:0] divider_count, divider_count_next;
  logic [4:0]  nibble_position, nibble_position_next;
  logic [3:0]  held_nibble, held_nibble_next;
  logic        fetch_hold, fetch_hold_next;
  logic [7:0]  read_data_next;

  logic [4:0]  pos_inc;
  logic        is_wave;
  logic        access_ok;
  logic [11:0] div_dec;
  logic [8:0]  len_tmp;
  logic        chan_tmp;

  assign pos_inc   = nibble_position + 5'd1;
  assign is_wave   = (item.addr >= ADDR_WAVE_LO) && (item.addr <= ADDR_WAVE_HI);
  assign access_ok = color_mode || fetch_hold;
  assign div_dec   = divider_count - 12'd1;

  always_comb begin
    if (op_t'(item.op) == OP_TICK) wave_rd_idx = pos_inc[4:1];
    else if (chan_enable)          wave_rd_idx = nibble_position[4:1];
    else                           wave_rd_idx = item.addr[WAVE_IDX_W-1:0];
  end

  always_comb begin
    chan_enable_next     = chan_enable;
    dac_on_next          = dac_on;
    vol_code_next        = vol_code;
    freq_value_next      = freq_value;
    length_enable_next   = length_enable;
    out_sample_next      = out_sample;
    length_count_next    = length_count;
    divider_count_next   = divider_count;
    nibble_position_next = nibble_position;
    held_nibble_next     = held_nibble;
    fetch_hold_next      = fetch_hold;
    read_data_next       = READ_IDLE;
    wave_ctl             = '0;
    len_tmp              = length_count;
    chan_tmp             = chan_enable;

    unique case (op_t'(item.op))
      OP_TICK: begin
        fetch_hold_next = 1'b0;
        if (divider_count != 12'd0) begin
          divider_count_next = div_dec;
          if (div_dec == 12'd0) begin
            divider_count_next   = DIV_PERIOD - {1'b0, freq_value};
            nibble_position_next = pos_inc;
            held_nibble_next     = pos_inc[0] ? wave_rd_data[3:0] : wave_rd_data[7:4];
            fetch_hold_next      = 1'b1;
          end
        end
        if (!chan_enable) begin
          out_sample_next = 4'd0;
        end else begin
          unique case (vol_code)
            2'd0: out_sample_next = 4'd0;
            2'd1: out_sample_next = held_nibble_next;
            2'd2: out_sample_next = held_nibble_next >> 1;
            2'd3: out_sample_next = held_nibble_next >> 2;
            default: out_sample_next = 4'd0;
          endcase
        end
      end

      OP_LENGTH: begin
        if (length_enable && length_count != 9'd0) begin
          length_count_next = length_count - 9'd1;
          if (length_count == 9'd1) chan_enable_next = 1'b0;
        end
      end

      OP_READ: begin
        if (item.addr == ADDR_DAC)
          read_data_next = {dac_on, 7'h7f};
        else if (item.addr == ADDR_VOLUME)
          read_data_next = {1'b1, vol_code, 5'h1f};
        else if (item.addr == ADDR_FREQ_HI)
          read_data_next = {1'b1, length_enable, 6'h3f};
        else if (is_wave && (!chan_enable || access_ok))
          read_data_next = wave_rd_data;
      end

      OP_WRITE: begin
        if (item.addr == ADDR_DAC) begin
          dac_on_next = item.data[7];
          if (!item.data[7]) chan_enable_next = 1'b0;
        end else if (item.addr == ADDR_LENGTH) begin
          length_count_next = LENGTH_FULL - {1'b0, item.data};
        end else if (item.addr == ADDR_VOLUME) begin
          vol_code_next = item.data[6:5];
        end else if (item.addr == ADDR_FREQ_LO) begin
          freq_value_next = {freq_value[10:8], item.data};
        end else if (item.addr == ADDR_FREQ_HI) begin
          // extra length clock when enabling at an odd phase
          if (item.odd && !length_enable && item.data[6] && length_count != 9'd0) begin
            len_tmp = length_count - 9'd1;
            if (len_tmp == 9'd0) chan_tmp = 1'b0;
          end
          length_enable_next = item.data[6];
          freq_value_next    = {item.data[2:0], freq_value[7:0]};
          length_count_next  = len_tmp;
          chan_enable_next   = chan_tmp;
          if (item.data[7]) begin
            wave_ctl.corrupt     = !color_mode && fetch_hold;
            wave_ctl.cur         = nibble_position[4:1];
            chan_enable_next     = dac_on;
            divider_count_next   = DIV_PERIOD - {1'b0, item.data[2:0], freq_value[7:0]};
            nibble_position_next = 5'd0;
            held_nibble_next     = 4'd0;
            fetch_hold_next      = 1'b0;
            if (len_tmp == 9'd0)
              length_count_next = (item.odd && item.data[6]) ? LENGTH_FULL - 9'd1
                                                             : LENGTH_FULL;
          end
        end else if (is_wave) begin
          if (!chan_enable) begin
            wave_ctl.we    = 1'b1;
            wave_ctl.waddr = item.addr[WAVE_IDX_W-1:0];
            wave_ctl.wdata = item.data;
          end else if (access_ok) begin
            wave_ctl.we    = 1'b1;
            wave_ctl.waddr = nibble_position[4:1];
            wave_ctl.wdata = item.data;
          end
        end
      end

      OP_RESET: begin
        chan_enable_next     = 1'b0;
        dac_on_next          = 1'b0;
        vol_code_next        = 2'd0;
        freq_value_next      = 11'd0;
        length_enable_next   = 1'b0;
        out_sample_next      = 4'd0;
        divider_count_next   = 12'd0;
        nibble_position_next = 5'd0;
        held_nibble_next     = 4'd0;
        fetch_hold_next      = 1'b0;
        if (item.init_len) length_count_next = LENGTH_FULL;
      end

      default: ;
    endcase

    // drop side effects unless the request is actually processed
    if (!fire) wave_ctl = '0;
  end

  assign result.read_data = read_data_next;
  assign result.sample    = out_sample_next;
  assign result.chan_on   = chan_enable_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_enable     <= 1'b0;
      dac_on          <= 1'b0;
      vol_code        <= 2'd0;
      freq_value      <= 11'd0;
      length_enable   <= 1'b0;
      out_sample      <= 4'd0;
      length_count    <= LENGTH_FULL;
      divider_count   <= 12'd0;
      nibble_position <= 5'd0;
      held_nibble     <= 4'd0;
      fetch_hold      <= 1'b0;
    end else if (fire) begin
      chan_enable     <= chan_enable_next;
      dac_on          <= dac_on_next;
      vol_code        <= vol_code_next;
      freq_value      <= freq_value_next;
      length_enable   <= length_enable_next;
      out_sample      <= out_sample_next;
      length_count    <= length_count_next;
      divider_count   <= divider_count_next;
      nibble_position <= nibble_position_next;
      held_nibble     <= held_nibble_next;
      fetch_hold      <= fetch_hold_next;
    end
  end

endmodule

// ===== rtl/core/wave_table_sound_channel_core.sv =====
// Wave-table sound channel core.
// Input channel (in_valid/in_ready): one request per item, selected by
// operation: sample tick, length clock, bus read, bus write or power reset,
// with address, write_data, sequencer_phase_odd and init_length alongside.
// Output channel (out_valid/out_ready): exactly one result per request,
// in order: read_data (0xff unless a bus read hits a readable register),
// sample_out and channel_on as they stand after the request.
// Config channel (cfg_valid/cfg_ready): writes color_model_mode; always
// ready, and meant to be written only while the core is idle.
// Accepted requests pass through an input register and then a result
// register, which is loaded from the state update when the request is
// processed. Throughput: one request per cycle while out_ready is high, set
// by the combinational state update between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and in_ready drops once both are occupied; requests
// resume at full rate as soon as out_ready returns.
// Reset (rst, synchronous): clears the channel state, sets the length
// counter to 256, clears the 16-byte wave RAM at once and empties both
// registers; color_model_mode returns to 0.
module wave_table_sound_channel_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic        sequencer_phase_odd,
  input  logic        init_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [3:0]  sample_out,
  output logic        channel_on,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import wtsc_pkg::*;

  logic                  color_mode;
  logic                  s1_valid;
  item_t                 s1_item;
  logic                  fire;
  result_t               result;
  result_t               out_result;
  logic [WAVE_IDX_W-1:0] wave_rd_idx;
  logic [7:0]            wave_rd_data;
  wave_ctl_t             wave_ctl;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      color_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.op       <= operation;
      s1_item.addr     <= address;
      s1_item.data     <= write_data;
      s1_item.odd      <= sequencer_phase_odd;
      s1_item.init_len <= init_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_result <= result;
  end

  assign read_data  = out_result.read_data;
  assign sample_out = out_result.sample;
  assign channel_on = out_result.chan_on;

  wtsc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (s1_item),
    .color_mode   (color_mode),
    .wave_rd_data (wave_rd_data),
    .wave_rd_idx  (wave_rd_idx),
    .wave_ctl     (wave_ctl),
    .result       (result)
  );

  wtsc_wave_ram u_wave (
    .clk     (clk),
    .rst     (rst),
    .ctl     (wave_ctl),
    .rd_idx  (wave_rd_idx),
    .rd_data (wave_rd_data)
  );

`ifndef SYNTH
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request did not produce a result");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are held");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !fire) |=> (s1_valid && $stable(s1_item)))
    else $error("stalled input stage changed");
`endif

endmodule
